FILE: hdl/sdve_pkg.sv
// Package: types and constants for the sample delta varint encoder.
`default_nettype none

package sdve_pkg;

   localparam int unsigned GroupBits = 7;
   localparam int unsigned DataBits  = 32;
   localparam int unsigned LenBits   = 4;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic signed [31:0] measure;
      logic [31:0]        timer_ms;
   } req_word_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               last;
      logic [LenBits-1:0] record_len;
   } rsp_word_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DT   = 5'b00010,
      ST_DM   = 5'b00100,
      ST_TM   = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      FLD_TIME  = 2'd0,
      FLD_MEAS  = 2'd1,
      FLD_TIMER = 2'd2
   } field_type;

   function automatic logic [DataBits-1:0] zigzag(input logic [DataBits-1:0] d);
      zigzag = {d[DataBits-2:0], 1'b0} ^ {DataBits{d[DataBits-1]}};
   endfunction

endpackage

`default_nettype wire

FILE: hdl/sample_delta_varint_encoder_core.sv
// Top level: delta, zigzag and LEB128 varint encoder for timed samples.
`default_nettype none

// One sample word produces a record of 2 to 15 bytes: the varint of the time
// delta, the zigzag varint of the measurement delta and, when include_timer is
// set, the varint of the timer value. A single 32-bit subtractor forms each
// value in its own state, then a work register shifted 7 bits per byte emits
// one byte per cycle while rsp_stall is low.
// After acceptance, each varint has a compute state followed by the emission of its
// bytes. req_stall stays high from acceptance until the last byte is taken.
module sample_delta_varint_encoder_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire sdve_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output sdve_pkg::rsp_word_type rsp_data,
   input  wire                   csr_write_enable,
   input  wire                   csr_write_data
);
   import sdve_pkg::*;

   state_type             state_ff, state_in;
   field_type             field_ff, field_in;
   logic                  include_timer_ff;
   logic [DataBits-1:0]   prev_time_ff, prev_measure_ff;
   logic [DataBits-1:0]   time_ff, measure_ff, timer_ff;
   logic [DataBits-1:0]   work_ff, work_in;
   logic [LenBits-1:0]    count_ff, count_in;
   logic [DataBits-1:0]   alu_a, alu_b, alu_out;
   logic                  req_take, rsp_take, more, final_byte;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

   assign more       = (work_ff[DataBits-1:GroupBits] != '0);
   assign final_byte = !more &&
      ((field_ff == FLD_TIMER) || (field_ff == FLD_MEAS && !include_timer_ff));

   always_comb begin
      rsp_data.out_byte   = {more, work_ff[GroupBits-1:0]};
      rsp_data.last       = final_byte;
      rsp_data.record_len = final_byte ? count_ff + 4'd1 : '0;
   end

   // shared subtractor
   always_comb begin
      case (state_ff)
         ST_DT: begin
            alu_a = time_ff;
            alu_b = prev_time_ff;
         end
         ST_DM: begin
            alu_a = measure_ff;
            alu_b = prev_measure_ff;
         end
         default: begin
            alu_a = timer_ff;
            alu_b = '0;
         end
      endcase
      alu_out = alu_a - alu_b;
   end

   always_comb begin
      state_in = state_ff;
      field_in = field_ff;
      work_in  = work_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (req_take) begin
               state_in = ST_DT;
            end
         end
         ST_DT: begin
            work_in  = alu_out;
            field_in = FLD_TIME;
            state_in = ST_EMIT;
         end
         ST_DM: begin
            work_in  = zigzag(alu_out);
            field_in = FLD_MEAS;
            state_in = ST_EMIT;
         end
         ST_TM: begin
            work_in  = alu_out;
            field_in = FLD_TIMER;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_take) begin
               count_in = count_ff + 4'd1;
               if (more) begin
                  work_in = work_ff >> GroupBits;
               end else if (final_byte) begin
                  state_in = ST_IDLE;
               end else if (field_ff == FLD_TIME) begin
                  state_in = ST_DM;
               end else begin
                  state_in = ST_TM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         include_timer_ff <= 1'b0;
         prev_time_ff     <= '0;
         prev_measure_ff  <= '0;
         count_ff         <= '0;
         field_ff         <= FLD_TIME;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         field_ff <= field_in;
         if (csr_write_enable) begin
            include_timer_ff <= csr_write_data;
         end
         if (rsp_take && final_byte) begin
            prev_time_ff    <= time_ff;
            prev_measure_ff <= measure_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (req_take) begin
         time_ff    <= req_data.time_ms;
         measure_ff <= $unsigned(req_data.measure);
         timer_ff   <= req_data.timer_ms;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall && !rsp_valid)
      else $error("block not busy after sample accepted");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_data.last) |=> !rsp_valid && !req_stall)
      else $error("block not idle after last byte");

   a_len_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.record_len >= 4'd2))
      else $error("record length too short");

   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> (rsp_data.record_len == '0))
      else $error("record length set on inner byte");

endmodule

`default_nettype wire

FILE: test/sample_delta_varint_encoder_core_tb.sv
// Testbench: random and directed samples, byte stream checked against a local encoder.
`default_nettype none

module sample_delta_varint_encoder_core_tb;
   import sdve_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_write_enable = 1'b0;
   logic         csr_write_data = 1'b0;

   req_word_type pending_samples [$];
   rsp_word_type expected_bytes [$];

   logic [31:0]  last_time = '0;
   logic [31:0]  last_measure = '0;
   logic         timer_on = 1'b0;

   int           mismatch_count = 0;
   int           samples_taken = 0;
   int           bytes_checked = 0;
   int           timer_phases = 0;
   int           phase_count = 0;

   sample_delta_varint_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("sample_delta_varint_encoder_core test failed");
      $finish;
   end

   // Expected record of one sample: time delta, zigzag measure delta, optional timer.
   function automatic void encode_record(input req_word_type w);
      logic [31:0]  vals [3];
      logic [31:0]  v;
      rsp_word_type rec [$];
      rsp_word_type b;
      int           nf;
      vals[0] = w.time_ms - last_time;
      v = w.measure - last_measure;
      vals[1] = {v[30:0], 1'b0} ^ {32{v[31]}};
      vals[2] = w.timer_ms;
      nf = timer_on ? 3 : 2;
      for (int f = 0; f < nf; f++) begin
         v = vals[f];
         while (v >= 32'h80) begin
            b.out_byte = {1'b1, v[6:0]};
            b.last = 1'b0;
            b.record_len = '0;
            rec.push_back(b);
            v = v >> 7;
         end
         b.out_byte = v[7:0];
         b.last = 1'b0;
         b.record_len = '0;
         rec.push_back(b);
      end
      b = rec.pop_back();
      b.last = 1'b1;
      b.record_len = LenBits'(rec.size() + 1);
      rec.push_back(b);
      foreach (rec[i]) expected_bytes.push_back(rec[i]);
      last_time = w.time_ms;
      last_measure = w.measure;
   endfunction

   function automatic void flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   // Sender: bursts of random length, random gaps between them.
   always @(posedge clock) begin : drive_proc
      int burst_left;
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_record(req_data);
            samples_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_data <= pending_samples.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern switches between modes: none, sparse, dense and alternating runs.
   always @(posedge clock) begin : check_proc
      int           stall_mode;
      int           stall_hold;
      int           stall_run;
      logic         run_level;
      logic         next_stall;
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_mode = 0;
         stall_hold = 0;
         stall_run = 0;
         run_level = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               flag_error($sformatf("unexpected word byte=%02h last=%0b len=%0d",
                  rsp_data.out_byte, rsp_data.last, rsp_data.record_len));
            end else begin
               want = expected_bytes.pop_front();
               bytes_checked++;
               if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last ||
                   rsp_data.record_len !== want.record_len)
                  flag_error($sformatf(
                     "expected byte=%02h last=%0b len=%0d, got byte=%02h last=%0b len=%0d",
                     want.out_byte, want.last, want.record_len,
                     rsp_data.out_byte, rsp_data.last, rsp_data.record_len));
            end
         end
         if (stall_hold <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_hold = $urandom_range(20, 200);
         end
         stall_hold--;
         case (stall_mode)
            0: next_stall = 1'b0;
            1: next_stall = ($urandom_range(0, 3) == 0);
            2: next_stall = ($urandom_range(0, 3) != 0);
            default: begin
               if (stall_run <= 0) begin
                  run_level = ~run_level;
                  stall_run = $urandom_range(1, 12);
               end
               stall_run--;
               next_stall = run_level;
            end
         endcase
         rsp_stall <= next_stall;
      end
   end

   task automatic write_timer_mode(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timer_on = value;
      phase_count++;
      if (value) timer_phases++;
   endtask

   task automatic wait_drained(input int tail);
      @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   function automatic req_word_type make_sample(input logic [31:0] t, input logic [31:0] m,
                                                input logic [31:0] tm);
      req_word_type w;
      w.time_ms = t;
      w.measure = m;
      w.timer_ms = tm;
      return w;
   endfunction

   function automatic logic [31:0] step_size();
      int k;
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 127);
         1: begin
            k = $urandom_range(1, 4);
            return (32'd1 << (7 * k)) - $urandom_range(0, 1);
         end
         2: return $urandom();
         3: return 32'hFFFF_FFFF - $urandom_range(0, 200);
         4: return $urandom_range(0, 20000);
         default: return $urandom_range(0, 3000000);
      endcase
   endfunction

   initial begin : stimulus_proc
      logic [31:0] gen_time;
      logic [31:0] gen_meas;
      logic [31:0] timers [10];
      logic        mode;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Timer off: byte-count boundaries, sign flips, wrapping deltas.
      write_timer_mode(1'b0);
      pending_samples.push_back(make_sample(32'd0, 32'd0, 32'hDEAD_BEEF));
      pending_samples.push_back(make_sample(32'd127, 32'd1, 32'd0));
      pending_samples.push_back(make_sample(32'd255, 32'd0, 32'hFFFF_FFFF));
      pending_samples.push_back(make_sample(32'd255, 32'd64, 32'd0));
      pending_samples.push_back(make_sample(32'hFFFF_FFFF, 32'h8000_0040, 32'd0));
      pending_samples.push_back(make_sample(32'd0, 32'h7FFF_FFFF, 32'd0));
      pending_samples.push_back(make_sample(32'h1000_0000, 32'h8000_0000, 32'd0));
      pending_samples.push_back(make_sample(32'h1000_0000, 32'h0000_0000, 32'd0));
      pending_samples.push_back(make_sample(32'h0FFF_FFFF, 32'h7FFF_FFFF, 32'd0));
      wait_drained(25);

      // Timer on: timer at each varint length boundary, then a full-length record.
      write_timer_mode(1'b1);
      timers = '{32'd0, 32'd127, 32'd128, 32'd16383, 32'd16384, 32'h001F_FFFF,
                 32'h0020_0000, 32'h0FFF_FFFF, 32'h1000_0000, 32'hFFFF_FFFF};
      gen_time = 32'h0FFF_FFFF;
      gen_meas = 32'h7FFF_FFFF;
      foreach (timers[i]) begin
         if (i > 0) gen_time = gen_time + (32'd1 << (3 * i));
         pending_samples.push_back(make_sample(gen_time, gen_meas, timers[i]));
      end
      gen_time = gen_time + 32'h8000_0000;
      gen_meas = gen_meas + 32'h4000_0000;
      pending_samples.push_back(make_sample(gen_time, gen_meas, 32'hFFFF_FFFF));
      wait_drained(25);

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: mode = 1'b0;
            1: mode = 1'b1;
            2: mode = 1'b0;
            3: mode = 1'b1;
            default: mode = 1'($urandom_range(0, 1));
         endcase
         write_timer_mode(mode);
         for (int half = 0; half < 2; half++) begin
            for (int i = 0; i < 50; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  gen_time = $urandom();
                  gen_meas = $urandom();
               end else begin
                  gen_time = gen_time + step_size();
                  gen_meas = gen_meas + step_size();
               end
               pending_samples.push_back(make_sample(gen_time, gen_meas, step_size()));
            end
            wait_drained(half == 0 ? $urandom_range(0, 10) : 25);
         end
      end

      if (expected_bytes.size() != 0)
         flag_error($sformatf("%0d bytes never arrived", expected_bytes.size()));
      $display("Covered %0d samples and %0d bytes over %0d mode settings (%0d with timer).",
         samples_taken, bytes_checked, phase_count, timer_phases);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("sample_delta_varint_encoder_core test passed");
      end else begin
         $display("sample_delta_varint_encoder_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
